@@ hw/rtl/smas_pkg.sv @@
// ----------------------------------------------------------------------------
// smas_pkg
// Types and constants shared by the square matrix add/subtract/multiply unit.
// ----------------------------------------------------------------------------
package smas_pkg;

   // Signed Q16.16 element, a truncated Q32.16 partial product, the per-element
   // accumulator (eight partial products) and the run total.
   localparam int VALUE_W = 32;
   localparam int TERM_W  = 48;
   localparam int ACC_W   = 52;
   localparam int TOTAL_W = 40;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int FRAC_W  = 16;

   localparam int SIZE_W = 4;
   localparam int OP_W   = 2;
   localparam int POS_W  = 3;

   // Input word actions.
   localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
   localparam logic [1:0] ACT_COMPUTE     = 2'd2;

   // Operation register codes; the unused code also selects the product.
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_OPERATION   = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_ACC,
      S_FIN,
      S_EMIT
   } state_type;

endpackage

@@ hw/rtl/square_matrix_add_sub_mult.sv @@
// Load words are accepted back to back.
// A compute word is worked one result element at a time through one shared
// multiply/add unit: the sequencer runs the read, multiply and accumulate
// steps in turn for every term, one term for an element-wise result and n
// terms for a product element (n = size), then finishes and emits it.
// The block takes no input word until the last result word has been taken.
// Synchronous active-high reset restores size 8 and the product operation;
// the matrix stores are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
// square_matrix_add_sub_mult
// Two square Q16.16 matrices held in RAM; on a compute word the unit emits
// their sum, difference or product in row-major order, the total on the last word.
// ----------------------------------------------------------------------------
module square_matrix_add_sub_mult
   import smas_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic [POS_W-1:0]          req_row_index,
   input  logic [POS_W-1:0]          req_col_index,
   input  logic signed [VALUE_W-1:0] req_element_value,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POS_W-1:0]          rsp_out_row,
   output logic [POS_W-1:0]          rsp_out_col,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic signed [TOTAL_W-1:0] rsp_total_sum,
   output logic                      rsp_last,

   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [SIZE_W-1:0]         csr_write_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FULL_W = 2 * POS_W;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] size_ff;
   logic [OP_W-1:0]   op_ff;

   logic [POS_W-1:0] n_last_ff, n_last_in;
   logic             mul_mode_ff, mul_mode_in;
   logic [POS_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic signed [TERM_W-1:0]  term_ff, term_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;

   logic [POS_W-1:0]          out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic signed [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic                      out_last_ff, out_last_in;

   logic              req_accept;
   logic              load_in_range;
   logic [FULL_W-1:0] load_full_addr, rd_full_a, rd_full_b;
   logic              wr_first, wr_second;
   logic [POS_W-1:0]  a_col, b_row;
   logic [VALUE_W-1:0] rd_first, rd_second;

   logic signed [PROD_W-1:0]  prod;
   logic signed [VALUE_W:0]   ew_sum;
   logic signed [VALUE_W-1:0] sat;
   logic                      acc_overflow;
   logic [SIZE_W-1:0]         size_eff;

   assign req_accept = req_valid && !req_stall;

   // Loads outside the array are dropped.
   assign load_in_range = ({1'b0, req_row_index} < SIZE_W'(MAX_DIM))
                        && ({1'b0, req_col_index} < SIZE_W'(MAX_DIM));
   assign load_full_addr = FULL_W'(req_row_index) * FULL_W'(MAX_DIM)
                         + FULL_W'(req_col_index);
   assign wr_first  = req_accept && load_in_range && (req_action == ACT_LOAD_FIRST);
   assign wr_second = req_accept && load_in_range && (req_action == ACT_LOAD_SECOND);

   // A product walks row i of the first matrix and column j of the second.
   assign a_col = mul_mode_ff ? k_ff : j_ff;
   assign b_row = mul_mode_ff ? k_ff : i_ff;
   assign rd_full_a = FULL_W'(i_ff) * FULL_W'(MAX_DIM) + FULL_W'(a_col);
   assign rd_full_b = FULL_W'(b_row) * FULL_W'(MAX_DIM) + FULL_W'(j_ff);

   smas_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_first_store (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (load_full_addr[ADDR_W-1:0]),
      .wr_data (req_element_value),
      .rd_addr (rd_full_a[ADDR_W-1:0]),
      .rd_data (rd_first)
   );

   smas_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_second_store (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (load_full_addr[ADDR_W-1:0]),
      .wr_data (req_element_value),
      .rd_addr (rd_full_b[ADDR_W-1:0]),
      .rd_data (rd_second)
   );

   // Shared arithmetic: one multiplier or one 33-bit add/subtract per term.
   assign prod   = $signed(rd_first) * $signed(rd_second);
   assign ew_sum = (op_ff == OP_SUB)
                 ? ($signed({rd_first[VALUE_W-1], rd_first})
                    - $signed({rd_second[VALUE_W-1], rd_second}))
                 : ($signed({rd_first[VALUE_W-1], rd_first})
                    + $signed({rd_second[VALUE_W-1], rd_second}));

   // Saturate when the bits above the sign of a 32-bit value disagree.
   assign acc_overflow = !((&acc_ff[ACC_W-1:VALUE_W-1]) || !(|acc_ff[ACC_W-1:VALUE_W-1]));
   always_comb begin
      if (!acc_overflow) begin
         sat = acc_ff[VALUE_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         size_eff = SIZE_W'(MAX_DIM);
      end else begin
         size_eff = size_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_last_in    = n_last_ff;
      mul_mode_in  = mul_mode_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_value_in = out_value_ff;
      out_total_in = out_total_ff;
      out_last_in  = out_last_ff;
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_accept && (req_action == ACT_COMPUTE)) begin
               n_last_in   = POS_W'(size_eff - SIZE_W'(1));
               mul_mode_in = (op_ff != OP_ADD) && (op_ff != OP_SUB);
               i_in        = '0;
               j_in        = '0;
               k_in        = '0;
               acc_in      = '0;
               total_in    = '0;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_mode_ff) begin
               term_in = prod[PROD_W-1:FRAC_W];
            end else begin
               term_in = TERM_W'(ew_sum);
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + ACC_W'(term_ff);
            if (!mul_mode_ff || (k_ff == n_last_ff)) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff + POS_W'(1);
               state_in = S_READ;
            end
         end
         S_FIN: begin
            total_in     = total_ff + TOTAL_W'(sat);
            out_row_in   = i_ff;
            out_col_in   = j_ff;
            out_value_in = sat;
            out_last_in  = (i_ff == n_last_ff) && (j_ff == n_last_ff);
            out_total_in = out_last_in ? total_in : '0;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               k_in   = '0;
               acc_in = '0;
               if (out_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  if (j_ff == n_last_ff) begin
                     j_in = '0;
                     i_in = i_ff + POS_W'(1);
                  end else begin
                     j_in = j_ff + POS_W'(1);
                  end
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= SIZE_RESET;
         op_ff    <= OP_MUL;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MATRIX_SIZE: size_ff <= csr_write_data;
               CSR_OPERATION:   op_ff   <= csr_write_data[OP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_last_ff    <= n_last_in;
      mul_mode_ff  <= mul_mode_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      term_ff      <= term_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_value_ff <= out_value_in;
      out_total_ff <= out_total_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_total_sum = out_total_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ hw/rtl/smas_ram.sv @@
// ----------------------------------------------------------------------------
// smas_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
